/* hdl/key_to_id_hash_map_top_assert.svh */
// Assertion macros for the key to id hash map.
// Used by the datapath; expects clk and rst_n in scope.
`ifndef KEY_TO_ID_HASH_MAP_TOP_ASSERT_SVH
`define KEY_TO_ID_HASH_MAP_TOP_ASSERT_SVH

// same-cycle implication
`define KTHM_ASSERT_IMPL(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define KTHM_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* hdl/kthm_pkg.sv */
// Package for the key to id hash map: sizes, word types, row layouts,
// and the controller/datapath command and status structs. No dependencies.
package kthm_pkg;

    localparam int BUCKETS  = 256;   // power of two, at most 8192
    localparam int WAYS     = 4;
    localparam int MAX_IDS  = 4096;
    localparam int KEY_BITS = 48;

    localparam int ID_W   = 12;
    localparam int BKT_W  = $clog2(BUCKETS);
    localparam int FILL_W = $clog2(WAYS + 1);
    localparam int CNT_W  = $clog2(MAX_IDS + 1);
    localparam int ENDS_W = 2 * ID_W;
    localparam int DUM_W  = ID_W + 1;

    typedef struct packed {
        logic                action;
        logic [KEY_BITS-1:0] key;
        logic [ID_W-1:0]     from_id;
        logic [ID_W-1:0]     to_id;
    } req_t;

    typedef struct packed {
        logic            found;
        logic [ID_W-1:0] entry_id;
        logic            dummy_made;
        logic [ID_W-1:0] dummy_id;
        logic            full_res;
    } rsp_t;

    typedef struct packed {
        logic [KEY_BITS-1:0] key;
        logic [ID_W-1:0]     id;
    } node_ent_t;

    typedef struct packed {
        logic [ENDS_W-1:0] ends;
        logic [ID_W-1:0]   index;
        logic [DUM_W-1:0]  dummy;
    } edge_ent_t;

    typedef struct packed {
        logic [FILL_W-1:0]          fill;
        node_ent_t [WAYS-1:0]       ways;
    } node_row_t;

    typedef struct packed {
        logic [FILL_W-1:0]          fill;
        edge_ent_t [WAYS-1:0]       ways;
    } edge_row_t;

    typedef struct packed {
        logic clear;
        logic load;
        logic commit;
    } cmd_t;

    typedef struct packed {
        logic clear_last;
        logic out_busy;
    } stat_t;

endpackage

/* hdl/kthm_ram.sv */
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module kthm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

/* hdl/kthm_ctrl.sv */
// Controller for the key to id hash map: clear pass, accept, evaluate.
// Depends on kthm_pkg.
module kthm_ctrl import kthm_pkg::*; (
    input  logic  clk,
    input  logic  rst_n,
    input  logic  req_valid,
    output logic  req_ready,
    input  stat_t stat,
    output cmd_t  cmd
);

    localparam logic [1:0] ST_CLEAR = 2'd0;
    localparam logic [1:0] ST_IDLE  = 2'd1;
    localparam logic [1:0] ST_EVAL  = 2'd2;

    logic [1:0] state_reg;
    logic [1:0] state_next;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        req_ready  = 1'b0;
        unique case (state_reg)
            ST_CLEAR:
            begin
                cmd.clear = 1'b1;
                if (stat.clear_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                req_ready = 1'b1;
                if (req_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_EVAL;
                end
            end
            ST_EVAL:
            begin
                if (!stat.out_busy)
                begin
                    cmd.commit = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_CLEAR;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

/* hdl/kthm_dp.sv */
// Datapath for the key to id hash map: bucket row RAMs, way compare,
// id counters and result register. Depends on kthm_pkg, kthm_ram, assert macros.
`include "key_to_id_hash_map_top_assert.svh"

module kthm_dp import kthm_pkg::*; (
    input  logic  clk,
    input  logic  rst_n,
    input  cmd_t  cmd,
    output stat_t stat,
    input  req_t  req,
    output rsp_t  rsp,
    output logic  rsp_valid,
    input  logic  rsp_ready
);

    req_t             req_reg;
    rsp_t             rsp_reg;
    rsp_t             rsp_next;
    logic             rsp_valid_reg;
    logic             rsp_valid_next;
    logic [BKT_W-1:0] clr_cnt_reg;
    logic [CNT_W-1:0] node_cnt_reg;
    logic [CNT_W-1:0] node_cnt_next;
    logic [CNT_W-1:0] edge_cnt_reg;
    logic [CNT_W-1:0] edge_cnt_next;

    logic [ID_W:0]    in_sum;
    logic [ID_W:0]    reg_sum;
    logic [BKT_W-1:0] node_waddr;
    logic [BKT_W-1:0] edge_waddr;
    logic             node_we;
    logic             edge_we;
    node_row_t        node_rdata;
    edge_row_t        edge_rdata;
    node_row_t        node_wdata;
    edge_row_t        edge_wdata;
    node_row_t        node_row_new;
    edge_row_t        edge_row_new;

    logic             n_hit;
    logic [ID_W-1:0]  n_hit_id;
    logic             n_free;
    logic             n_ins;
    logic             e_hit;
    logic [ID_W-1:0]  e_hit_idx;
    logic [DUM_W-1:0] e_hit_dum;
    logic             e_free;
    logic             e_ins;
    logic             e_loop;
    logic             node_room;
    logic             edge_room;
    logic [ENDS_W-1:0] ends;

    // bucket hash
    assign in_sum  = {1'b0, req.from_id} + {1'b0, req.to_id};
    assign reg_sum = {1'b0, req_reg.from_id} + {1'b0, req_reg.to_id};
    assign ends    = {req_reg.from_id, req_reg.to_id};
    assign e_loop  = req_reg.from_id == req_reg.to_id;

    assign node_room = node_cnt_reg < CNT_W'(MAX_IDS);
    assign edge_room = edge_cnt_reg < CNT_W'(MAX_IDS);

    always_comb
    begin
        n_hit     = 1'b0;
        n_hit_id  = '0;
        e_hit     = 1'b0;
        e_hit_idx = '0;
        e_hit_dum = '0;
        node_row_new      = node_rdata;
        node_row_new.fill = node_rdata.fill + FILL_W'(1);
        edge_row_new      = edge_rdata;
        edge_row_new.fill = edge_rdata.fill + FILL_W'(1);
        for (int w = WAYS - 1; w >= 0; w--)
        begin
            if (FILL_W'(w) < node_rdata.fill && node_rdata.ways[w].key == req_reg.key)
            begin
                n_hit    = 1'b1;
                n_hit_id = node_rdata.ways[w].id;
            end
            if (FILL_W'(w) < edge_rdata.fill && edge_rdata.ways[w].ends == ends)
            begin
                e_hit     = 1'b1;
                e_hit_idx = edge_rdata.ways[w].index;
                e_hit_dum = edge_rdata.ways[w].dummy;
            end
            if (FILL_W'(w) == node_rdata.fill)
            begin
                node_row_new.ways[w].key = req_reg.key;
                node_row_new.ways[w].id  = node_cnt_reg[ID_W-1:0];
            end
            if (FILL_W'(w) == edge_rdata.fill)
            begin
                edge_row_new.ways[w].ends  = ends;
                edge_row_new.ways[w].index = edge_cnt_reg[ID_W-1:0];
                edge_row_new.ways[w].dummy = e_loop ? {1'b1, node_cnt_reg[ID_W-1:0]}
                                                    : DUM_W'(0);
            end
        end
    end

    assign n_free = node_rdata.fill < FILL_W'(WAYS);
    assign e_free = edge_rdata.fill < FILL_W'(WAYS);
    assign n_ins  = !req_reg.action && !n_hit && n_free && node_room;
    assign e_ins  = req_reg.action && !e_hit && e_free && edge_room && (!e_loop || node_room);

    always_comb
    begin
        rsp_next = '0;
        if (!req_reg.action)
        begin
            priority if (n_hit)
            begin
                rsp_next.found    = 1'b1;
                rsp_next.entry_id = n_hit_id;
            end
            else if (n_ins)
            begin
                rsp_next.entry_id = node_cnt_reg[ID_W-1:0];
            end
            else
            begin
                rsp_next.full_res = 1'b1;
            end
        end
        else
        begin
            priority if (e_hit)
            begin
                rsp_next.found    = 1'b1;
                rsp_next.entry_id = e_hit_idx;
                rsp_next.dummy_id = e_hit_dum[ID_W] ? e_hit_dum[ID_W-1:0] : ID_W'(0);
            end
            else if (e_ins)
            begin
                rsp_next.entry_id   = edge_cnt_reg[ID_W-1:0];
                rsp_next.dummy_made = e_loop;
                rsp_next.dummy_id   = e_loop ? node_cnt_reg[ID_W-1:0] : ID_W'(0);
            end
            else
            begin
                rsp_next.full_res = 1'b1;
            end
        end
    end

    always_comb
    begin
        node_cnt_next = node_cnt_reg;
        edge_cnt_next = edge_cnt_reg;
        if (cmd.commit)
        begin
            if (n_ins || (e_ins && e_loop))
            begin
                node_cnt_next = node_cnt_reg + CNT_W'(1);
            end
            if (e_ins)
            begin
                edge_cnt_next = edge_cnt_reg + CNT_W'(1);
            end
        end
    end

    always_comb
    begin
        rsp_valid_next = rsp_valid_reg;
        priority if (cmd.commit)
        begin
            rsp_valid_next = 1'b1;
        end
        else if (rsp_ready)
        begin
            rsp_valid_next = 1'b0;
        end
        else
        begin
            rsp_valid_next = rsp_valid_reg;
        end
    end

    // row write: clear pass zeroes the fill count, commit writes back one way
    assign node_waddr = cmd.clear ? clr_cnt_reg : req_reg.key[BKT_W-1:0];
    assign edge_waddr = cmd.clear ? clr_cnt_reg : reg_sum[BKT_W-1:0];
    assign node_we    = cmd.clear || (cmd.commit && n_ins);
    assign edge_we    = cmd.clear || (cmd.commit && e_ins);
    assign node_wdata = cmd.clear ? node_row_t'(0) : node_row_new;
    assign edge_wdata = cmd.clear ? edge_row_t'(0) : edge_row_new;

    kthm_ram #(
        .WIDTH ($bits(node_row_t)),
        .DEPTH (BUCKETS)
    ) u_node_ram (
        .clk   (clk),
        .we    (node_we),
        .waddr (node_waddr),
        .wdata (node_wdata),
        .re    (cmd.load),
        .raddr (req.key[BKT_W-1:0]),
        .rdata (node_rdata)
    );

    kthm_ram #(
        .WIDTH ($bits(edge_row_t)),
        .DEPTH (BUCKETS)
    ) u_edge_ram (
        .clk   (clk),
        .we    (edge_we),
        .waddr (edge_waddr),
        .wdata (edge_wdata),
        .re    (cmd.load),
        .raddr (in_sum[BKT_W-1:0]),
        .rdata (edge_rdata)
    );

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            req_reg <= req;
        end
        if (cmd.commit)
        begin
            rsp_reg <= rsp_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_valid_reg <= 1'b0;
            clr_cnt_reg   <= '0;
            node_cnt_reg  <= '0;
            edge_cnt_reg  <= '0;
        end
        else
        begin
            rsp_valid_reg <= rsp_valid_next;
            node_cnt_reg  <= node_cnt_next;
            edge_cnt_reg  <= edge_cnt_next;
            if (cmd.clear)
            begin
                clr_cnt_reg <= clr_cnt_reg + BKT_W'(1);
            end
        end
    end

    assign stat.clear_last = clr_cnt_reg == BKT_W'(BUCKETS - 1);
    assign stat.out_busy   = rsp_valid_reg && !rsp_ready;
    assign rsp             = rsp_reg;
    assign rsp_valid       = rsp_valid_reg;

    `KTHM_ASSERT_IMPL(a_no_overwrite, cmd.commit, !rsp_valid_reg || rsp_ready,
        "result word overwritten while waiting")
    `KTHM_ASSERT_IMPL(a_cnt_bound, 1'b1,
        node_cnt_reg <= CNT_W'(MAX_IDS) && edge_cnt_reg <= CNT_W'(MAX_IDS),
        "id counter beyond id space")
    `KTHM_ASSERT_NEXT(a_edge_cnt, cmd.commit && e_ins,
        edge_cnt_reg == $past(edge_cnt_reg) + CNT_W'(1),
        "edge counter did not advance on insert")
    `KTHM_ASSERT_IMPL(a_rsp_src, $rose(rsp_valid_reg), $past(cmd.commit),
        "result valid without commit")

endmodule

/* hdl/key_to_id_hash_map_top.sv */
// A result word is registered on commit, in the evaluate state after acceptance.
// A new request waits until the last is committed, for the read-modify-write of
// one bucket row in each row RAM; a waiting result stalls the next evaluation.
// Reset: async, active low; a clearing pass over all BUCKETS (256) rows zeroes the
// bucket fill counts, with req_ready low until it ends.
module key_to_id_hash_map_top import kthm_pkg::*; (
    input  logic clk,
    input  logic rst_n,
    input  logic req_valid,
    output logic req_ready,
    input  req_t req,
    output logic rsp_valid,
    input  logic rsp_ready,
    output rsp_t rsp
);

    cmd_t  cmd;
    stat_t stat;

    kthm_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .stat      (stat),
        .cmd       (cmd)
    );

    kthm_dp u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .stat      (stat),
        .req       (req),
        .rsp       (rsp),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready)
    );

endmodule

/* tb/key_to_id_hash_map_top_test.sv */
// Self-checking testbench for key_to_id_hash_map_top: a directed and random request
// stream with random idling on both sides, checked against an in-bench map model.
// Depends on kthm_pkg and the key_to_id_hash_map_top RTL.
`timescale 1ns / 1ps

module key_to_id_hash_map_top_test;
    import kthm_pkg::*;

    localparam int SLOTS = BUCKETS * WAYS;
    localparam int IDLE_PCT = 21;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic req_valid = 1'b0;
    logic req_ready;
    req_t req = '0;
    logic rsp_valid;
    logic rsp_ready = 1'b0;
    rsp_t rsp;

    key_to_id_hash_map_top dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp)
    );

    // map model state
    bit                  nmap_valid [SLOTS];
    logic [KEY_BITS-1:0] nmap_key   [SLOTS];
    logic [ID_W-1:0]     nmap_id    [SLOTS];
    bit                  emap_valid [SLOTS];
    logic [ENDS_W-1:0]   emap_ends  [SLOTS];
    logic [ID_W-1:0]     emap_index [SLOTS];
    logic [DUM_W-1:0]    emap_dummy [SLOTS];
    int                  node_ids_used;
    int                  edge_ids_used;

    req_t                pending_words [$];
    rsp_t                expected_rsps [$];
    logic [KEY_BITS-1:0] key_pool [$];
    logic [ENDS_W-1:0]   ends_pool [$];

    int errors = 0;
    int n_accepted = 0;
    int hold_left = 0;
    bit held = 1'b0;
    wire idle_ok = !(n_accepted >= 1000 && n_accepted < 1400);

    function automatic rsp_t lookup_or_insert(req_t r);
        rsp_t o;
        int base;
        int free_slot;
        bit have_free;
        bit loop;
        logic [ENDS_W-1:0] ends;
        o = '0;
        free_slot = 0;
        have_free = 1'b0;
        if (r.action == 1'b0)
        begin
            base = int'(r.key % BUCKETS) * WAYS;
            for (int w = 0; w < WAYS; w++)
            begin
                if (nmap_valid[base + w])
                begin
                    if (nmap_key[base + w] == r.key)
                    begin
                        o.found = 1'b1;
                        o.entry_id = nmap_id[base + w];
                        return o;
                    end
                end
                else if (!have_free)
                begin
                    have_free = 1'b1;
                    free_slot = base + w;
                end
            end
            if (!have_free || node_ids_used >= MAX_IDS)
            begin
                o.full_res = 1'b1;
                return o;
            end
            nmap_valid[free_slot] = 1'b1;
            nmap_key[free_slot] = r.key;
            nmap_id[free_slot] = node_ids_used[ID_W-1:0];
            o.entry_id = node_ids_used[ID_W-1:0];
            node_ids_used++;
        end
        else
        begin
            ends = {r.from_id, r.to_id};
            loop = (r.from_id == r.to_id);
            base = ((int'(r.from_id) + int'(r.to_id)) % BUCKETS) * WAYS;
            for (int w = 0; w < WAYS; w++)
            begin
                if (emap_valid[base + w])
                begin
                    if (emap_ends[base + w] == ends)
                    begin
                        o.found = 1'b1;
                        o.entry_id = emap_index[base + w];
                        if (emap_dummy[base + w][ID_W])
                            o.dummy_id = emap_dummy[base + w][ID_W-1:0];
                        return o;
                    end
                end
                else if (!have_free)
                begin
                    have_free = 1'b1;
                    free_slot = base + w;
                end
            end
            if (!have_free || edge_ids_used >= MAX_IDS ||
                (loop && node_ids_used >= MAX_IDS))
            begin
                o.full_res = 1'b1;
                return o;
            end
            emap_valid[free_slot] = 1'b1;
            emap_ends[free_slot] = ends;
            emap_index[free_slot] = edge_ids_used[ID_W-1:0];
            o.entry_id = edge_ids_used[ID_W-1:0];
            if (loop)
            begin
                emap_dummy[free_slot] = {1'b1, node_ids_used[ID_W-1:0]};
                o.dummy_made = 1'b1;
                o.dummy_id = node_ids_used[ID_W-1:0];
                node_ids_used++;
            end
            else
            begin
                emap_dummy[free_slot] = '0;
            end
            edge_ids_used++;
        end
        return o;
    endfunction

    function automatic logic [KEY_BITS-1:0] rand_key();
        return KEY_BITS'({$urandom, $urandom});
    endfunction

    // unused fields get random content
    function automatic req_t make_word(logic act, logic [KEY_BITS-1:0] k,
                                       logic [ID_W-1:0] f, logic [ID_W-1:0] t);
        req_t r;
        r.action = act;
        r.key = act ? rand_key() : k;
        r.from_id = act ? f : ID_W'($urandom);
        r.to_id = act ? t : ID_W'($urandom);
        return r;
    endfunction

    function automatic req_t random_word();
        req_t r;
        logic [KEY_BITS-1:0] k;
        logic [ID_W-1:0] f;
        logic [ID_W-1:0] t;
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 30 || (roll < 50 && key_pool.size() == 0))
        begin
            k = rand_key();
            if ($urandom_range(0, 1))
                k[BKT_W-1:0] = BKT_W'($urandom_range(0, 63));
            key_pool.push_back(k);
            r = make_word(1'b0, k, '0, '0);
        end
        else if (roll < 50)
        begin
            r = make_word(1'b0, key_pool[$urandom_range(0, key_pool.size() - 1)], '0, '0);
        end
        else if (roll < 75 || (roll < 95 && ends_pool.size() == 0))
        begin
            f = ID_W'($urandom_range(0, 63));
            t = ID_W'($urandom_range(0, 63));
            if ($urandom_range(0, 3) == 0)
            begin
                f = ID_W'($urandom);
                t = ID_W'($urandom);
            end
            ends_pool.push_back({f, t});
            r = make_word(1'b1, '0, f, t);
        end
        else if (roll < 85)
        begin
            f = ID_W'($urandom);
            if ($urandom_range(0, 1))
                f[ID_W-1:6] = '0;
            ends_pool.push_back({f, f});
            r = make_word(1'b1, '0, f, f);
        end
        else if (roll < 95)
        begin
            {f, t} = ends_pool[$urandom_range(0, ends_pool.size() - 1)];
            r = make_word(1'b1, '0, f, t);
        end
        else
        begin
            r = req_t'({$urandom, $urandom, $urandom});
        end
        return r;
    endfunction

    initial
    begin
        forever #5 clk = ~clk;
    end

    initial
    begin
        #2000000;
        $display("key_to_id_hash_map_top_test: errors");
        $finish;
    end

    // driver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            req_valid <= 1'b0;
        end
        else if (!req_valid || req_ready)
        begin
            if (pending_words.size() > 0 &&
                !(idle_ok && $urandom_range(0, 99) < IDLE_PCT))
            begin
                req <= pending_words.pop_front();
                req_valid <= 1'b1;
            end
            else
            begin
                req_valid <= 1'b0;
            end
        end
    end

    // monitor: predicts on request acceptance, checks on response acceptance
    always @(posedge clk or negedge rst_n)
    begin
        rsp_t want;
        if (!rst_n)
        begin
            rsp_ready <= 1'b0;
        end
        else
        begin
            if (req_valid && req_ready)
            begin
                expected_rsps.push_back(lookup_or_insert(req));
                n_accepted <= n_accepted + 1;
            end
            if (rsp_valid && rsp_ready)
            begin
                if (expected_rsps.size() == 0)
                begin
                    $error("unexpected response word %h", rsp);
                    errors++;
                end
                else
                begin
                    want = expected_rsps.pop_front();
                    if (rsp.found !== want.found)
                    begin
                        $error("found: expected %0d, got %0d", want.found, rsp.found);
                        errors++;
                    end
                    if (rsp.entry_id !== want.entry_id)
                    begin
                        $error("entry_id: expected %0d, got %0d",
                               want.entry_id, rsp.entry_id);
                        errors++;
                    end
                    if (rsp.dummy_made !== want.dummy_made)
                    begin
                        $error("dummy_made: expected %0d, got %0d",
                               want.dummy_made, rsp.dummy_made);
                        errors++;
                    end
                    if (rsp.dummy_id !== want.dummy_id)
                    begin
                        $error("dummy_id: expected %0d, got %0d",
                               want.dummy_id, rsp.dummy_id);
                        errors++;
                    end
                    if (rsp.full_res !== want.full_res)
                    begin
                        $error("full_res: expected %0d, got %0d",
                               want.full_res, rsp.full_res);
                        errors++;
                    end
                end
            end
            // long back-pressure stretch once, mid-run
            if (!held && n_accepted >= 700)
            begin
                held <= 1'b1;
                hold_left <= 300;
                rsp_ready <= 1'b0;
            end
            else if (hold_left > 0)
            begin
                hold_left <= hold_left - 1;
                rsp_ready <= 1'b0;
            end
            else
            begin
                rsp_ready <= !(idle_ok && $urandom_range(0, 99) < IDLE_PCT);
            end
        end
    end

    initial
    begin
        logic [KEY_BITS-1:0] k;
        for (int i = 0; i < SLOTS; i++)
        begin
            nmap_valid[i] = 1'b0;
            emap_valid[i] = 1'b0;
        end
        node_ids_used = 0;
        edge_ids_used = 0;

        // key extremes and a hit
        pending_words.push_back(make_word(1'b0, '0, '0, '0));
        pending_words.push_back(make_word(1'b0, '1, '0, '0));
        pending_words.push_back(make_word(1'b0, '0, '0, '0));
        // overflow one node bucket, then hit inside the full bucket
        for (int i = 0; i < WAYS + 1; i++)
        begin
            k = rand_key();
            k[BKT_W-1:0] = BKT_W'(8'h11);
            if (i == 0)
                key_pool.push_back(k);
            pending_words.push_back(make_word(1'b0, k, '0, '0));
        end
        pending_words.push_back(make_word(1'b0, key_pool[0], '0, '0));
        // self-loops: new, found with its dummy, and another new one
        pending_words.push_back(make_word(1'b1, '0, '0, '0));
        pending_words.push_back(make_word(1'b1, '0, '0, '0));
        pending_words.push_back(make_word(1'b1, '0, '1, '1));
        // overflow edge bucket 255
        pending_words.push_back(make_word(1'b1, '0, '1, '0));
        pending_words.push_back(make_word(1'b1, '0, '0, '1));
        pending_words.push_back(make_word(1'b1, '0, 12'd1, 12'd254));
        pending_words.push_back(make_word(1'b1, '0, 12'd2, 12'd253));
        pending_words.push_back(make_word(1'b1, '0, 12'd3, 12'd252));
        // overflow edge bucket 254, incl. a self-loop that finds no room
        pending_words.push_back(make_word(1'b1, '0, 12'd127, 12'd127));
        pending_words.push_back(make_word(1'b1, '0, 12'd100, 12'd154));
        pending_words.push_back(make_word(1'b1, '0, 12'd101, 12'd153));
        pending_words.push_back(make_word(1'b1, '0, 12'd102, 12'd152));
        pending_words.push_back(make_word(1'b1, '0, 12'd255, 12'd255));
        pending_words.push_back(make_word(1'b1, '0, '1, '1));

        for (int i = 0; i < 1750; i++)
            pending_words.push_back(random_word());

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        while (pending_words.size() > 0 || req_valid)
            @(posedge clk);
        while (expected_rsps.size() > 0)
            @(posedge clk);
        repeat (10) @(posedge clk);

        if (errors == 0)
            $display("key_to_id_hash_map_top_test: clean");
        else
            $display("key_to_id_hash_map_top_test: errors");
        $finish;
    end

endmodule
